[src/wpl3_pkg.sv]
package wpl3_pkg;

  localparam int DEF_MAX_X = 256;
  localparam int DEF_MAX_Y = 256;
  localparam int DEF_MAX_Z = 256;

  localparam int PHASE_W = 16;
  localparam int SIZE_W  = 9;
  localparam int WGT_W   = 16;
  localparam int LAP_W   = 31;
  localparam int CFG_AW  = 3;

  // floor(a/7) split: 2^18 = 7*37449 + 1, 2^9 = 7*73 + 1, then 2341/2^14 for the rest
  localparam int DIV7_HI  = 37449;
  localparam int DIV7_MID = 73;
  localparam int DIV7_LO  = 2341;
  localparam int DIV7_SH  = 14;

  typedef enum logic [CFG_AW-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_INV_X  = 3'd3,
    REG_INV_Y  = 3'd4,
    REG_INV_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] c;
    logic [PHASE_W-1:0] xb;
    logic [PHASE_W-1:0] xf;
    logic [PHASE_W-1:0] yb;
    logic [PHASE_W-1:0] yf;
    logic [PHASE_W-1:0] zb;
    logic [PHASE_W-1:0] zf;
  } taps_t;

  typedef struct packed {
    logic has_xb;
    logic has_xf;
    logic has_yb;
    logic has_yf;
    logic has_zb;
    logic has_zf;
    logic last;
  } edge_ctl_t;

  // wrapped second difference in (-32768, 32768]
  function automatic logic signed [PHASE_W:0] wrap_diff(
    input logic [PHASE_W-1:0] f,
    input logic [PHASE_W-1:0] b,
    input logic [PHASE_W-1:0] c
  );
    logic [PHASE_W-1:0] t;
    t = f + b - {c[PHASE_W-2:0], 1'b0};
    return {t[PHASE_W-1] && (t != {1'b1, {(PHASE_W-1){1'b0}}}), t};
  endfunction

endpackage

[src/wrapped_phase_laplacian_3d.sv]
// Wrapped-phase 7-point Laplacian over a raster-ordered 3D volume (x fastest).
// Input channel (in_valid/in_ready): operation 0 carries one phase voxel,
// operation 1 is a drain item that releases one pending result once the whole
// volume is in. Output channel (out_valid/out_ready): one laplacian value per
// voxel, last_voxel marking the final voxel of the volume.
// The result for voxel n comes with sample n + size_x*size_y; the last plane
// comes out on drain items. Samples after a full volume are dropped.
// Accepts one item per cycle while the output is not stalled. The result shows
// on the output register after the item that releases it, passing through the
// plane delay lines, wrap stage, weight multiply, sum and three-step divide by 7.
// Neighbor history lives in four ring memories sized by MAX_X/MAX_Y.
// Reset clears positions and flow control; history needs no clearing pass.
// Writing any size register restarts the volume. A stalled receiver holds the
// whole pipeline: in_ready = !out_valid || out_ready.
// Config: cfg_we/cfg_addr/cfg_wdata, write only while idle.
module wrapped_phase_laplacian_3d #(
  parameter int MAX_X = wpl3_pkg::DEF_MAX_X,
  parameter int MAX_Y = wpl3_pkg::DEF_MAX_Y,
  parameter int MAX_Z = wpl3_pkg::DEF_MAX_Z
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wpl3_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [wpl3_pkg::WGT_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic signed [wpl3_pkg::PHASE_W-1:0] phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wpl3_pkg::LAP_W-1:0]   laplacian,
  output logic                                last_voxel
);
  import wpl3_pkg::*;

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [WGT_W-1:0]  inv_sq_spacing_x, inv_sq_spacing_y, inv_sq_spacing_z;
  logic              enable;
  logic              size_wr;
  taps_t             taps;
  edge_ctl_t         ctl;
  logic              ctl_valid;

  assign enable   = !out_valid || out_ready;
  assign in_ready = enable;

  always_comb begin
    size_wr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: size_wr = 1'b1;
        default: size_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 9'd256;
      size_y <= 9'd256;
      size_z <= 9'd256;
      inv_sq_spacing_x <= 16'd256;
      inv_sq_spacing_y <= 16'd256;
      inv_sq_spacing_z <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_SIZE_X: size_x <= cfg_wdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y <= cfg_wdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z <= cfg_wdata[SIZE_W-1:0];
        REG_INV_X:  inv_sq_spacing_x <= cfg_wdata;
        REG_INV_Y:  inv_sq_spacing_y <= cfg_wdata;
        REG_INV_Z:  inv_sq_spacing_z <= cfg_wdata;
        default: ;
      endcase
    end
  end

  wpl3_window #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_window (
    .clk, .rst, .enable, .clear(size_wr), .in_valid, .operation,
    .phase(phase), .size_x, .size_y, .size_z, .taps, .ctl, .ctl_valid
  );

  wpl3_arith u_arith (
    .clk, .rst, .enable, .taps, .ctl, .ctl_valid,
    .wx(inv_sq_spacing_x), .wy(inv_sq_spacing_y), .wz(inv_sq_spacing_z),
    .out_valid, .laplacian, .last_voxel
  );

endmodule

[src/wpl3_delay.sv]
module wpl3_delay #(
  parameter int DEPTH = 2,
  parameter int EW    = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         shift,
  input  logic                         clear,
  input  logic [EW-1:0]                delay,
  input  logic [wpl3_pkg::PHASE_W-1:0] din,
  output logic [wpl3_pkg::PHASE_W-1:0] dout
);
  import wpl3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [PHASE_W-1:0] mem [DEPTH];
  logic [AW-1:0]      ptr;
  logic [PHASE_W-1:0] r;
  logic [PHASE_W-1:0] q;
  logic               wrap;

  // ring of delay-1 entries; the read register adds the last step
  assign wrap = (delay < EW'(2)) || (EW'(ptr) == delay - EW'(2));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ptr <= '0;
    end else if (shift) begin
      ptr <= wrap ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      r        <= din;
      q        <= mem[ptr];
      mem[ptr] <= din;
    end
  end

  assign dout = (delay == '0) ? din : (delay == EW'(1)) ? r : q;

endmodule

[src/wpl3_window.sv]
module wpl3_window #(
  parameter int MAX_X = wpl3_pkg::DEF_MAX_X,
  parameter int MAX_Y = wpl3_pkg::DEF_MAX_Y,
  parameter int MAX_Z = wpl3_pkg::DEF_MAX_Z
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         enable,
  input  logic                         clear,
  input  logic                         in_valid,
  input  logic                         operation,
  input  logic [wpl3_pkg::PHASE_W-1:0] phase,
  input  logic [wpl3_pkg::SIZE_W-1:0]  size_x,
  input  logic [wpl3_pkg::SIZE_W-1:0]  size_y,
  input  logic [wpl3_pkg::SIZE_W-1:0]  size_z,
  output wpl3_pkg::taps_t              taps,
  output wpl3_pkg::edge_ctl_t          ctl,
  output logic                         ctl_valid
);
  import wpl3_pkg::*;

  localparam int XW = $clog2(MAX_X);
  localparam int YW = $clog2(MAX_Y);
  localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int DEPTH_A = MAX_X * (MAX_Y - 1) - 1;
  localparam int EWA = $clog2(DEPTH_A + 2);
  localparam int DEPTH_B = MAX_X - 2;
  localparam int EWB = $clog2(DEPTH_B + 2);
  localparam int PW = XW + YW + 1;

  logic [XW-1:0] sx_m1;
  logic [YW-1:0] sy_m1;
  logic [ZW-1:0] sz_m1;
  logic [PW-1:0] plane_rest;
  logic [EWA-1:0] delay_a;
  logic [EWB-1:0] delay_b;

  logic [XW-1:0] ix, ox;
  logic [YW-1:0] iy, oy;
  logic [ZW-1:0] iz, oz;
  logic primed, full;
  logic accept, take, drain, push, emit, o_last;

  logic [PHASE_W-1:0] newest, yf_t, xf_t, c_t, xb_t, yb_t, zb_t;

  always_comb begin
    sx_m1 = (size_x == '0) ? '0 :
            (32'(size_x) > MAX_X) ? XW'(MAX_X - 1) : XW'(size_x - 9'd1);
    sy_m1 = (size_y == '0) ? '0 :
            (32'(size_y) > MAX_Y) ? YW'(MAX_Y - 1) : YW'(size_y - 9'd1);
    sz_m1 = (size_z == '0) ? '0 :
            (32'(size_z) > MAX_Z) ? ZW'(MAX_Z - 1) : ZW'(size_z - 9'd1);
  end

  // plane - size_x = size_x * (size_y - 1)
  assign plane_rest = (PW'(sx_m1) + PW'(1)) * PW'(sy_m1);
  assign delay_a    = EWA'(plane_rest);
  assign delay_b    = EWB'(sx_m1);

  always_comb begin
    accept = in_valid && enable;
    take   = accept && !operation && !full;
    drain  = accept && operation && full;
    push   = take || drain;
    emit   = (take && primed) || drain;
    o_last = (ox == sx_m1) && (oy == sy_m1) && (oz == sz_m1);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      ix <= '0; iy <= '0; iz <= '0;
      ox <= '0; oy <= '0; oz <= '0;
      primed <= 1'b0;
      full   <= 1'b0;
    end else begin
      if (take) begin
        if (ix == sx_m1) begin
          ix <= '0;
          if (iy == sy_m1) begin
            iy     <= '0;
            primed <= 1'b1;
            if (iz == sz_m1) begin
              full <= 1'b1;
            end else begin
              iz <= iz + 1'b1;
            end
          end else begin
            iy <= iy + 1'b1;
          end
        end else begin
          ix <= ix + 1'b1;
        end
      end
      if (emit) begin
        if (o_last) begin
          ix <= '0; iy <= '0; iz <= '0;
          ox <= '0; oy <= '0; oz <= '0;
          primed <= 1'b0;
          full   <= 1'b0;
        end else if (ox == sx_m1) begin
          ox <= '0;
          if (oy == sy_m1) begin
            oy <= '0;
            oz <= oz + 1'b1;
          end else begin
            oy <= oy + 1'b1;
          end
        end else begin
          ox <= ox + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_valid <= 1'b0;
    end else if (enable) begin
      ctl_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (enable && emit) begin
      ctl.has_xb <= (ox != '0);
      ctl.has_xf <= (ox != sx_m1);
      ctl.has_yb <= (oy != '0);
      ctl.has_yf <= (oy != sy_m1);
      ctl.has_zb <= (oz != '0);
      ctl.has_zf <= (oz != sz_m1);
      ctl.last   <= o_last;
    end
  end

  // drain items push a filler sample; it only lands on edge-replaced taps
  always_ff @(posedge clk) begin
    if (push) begin
      newest <= phase;
    end
  end

  wpl3_delay #(.DEPTH(DEPTH_A), .EW(EWA)) u_dly_a (
    .clk, .rst, .shift(push), .clear, .delay(delay_a), .din(newest), .dout(yf_t)
  );

  wpl3_delay #(.DEPTH(DEPTH_B), .EW(EWB)) u_dly_b (
    .clk, .rst, .shift(push), .clear, .delay(delay_b), .din(yf_t), .dout(xf_t)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      c_t  <= xf_t;
      xb_t <= c_t;
    end
  end

  wpl3_delay #(.DEPTH(DEPTH_B), .EW(EWB)) u_dly_c (
    .clk, .rst, .shift(push), .clear, .delay(delay_b), .din(xb_t), .dout(yb_t)
  );

  wpl3_delay #(.DEPTH(DEPTH_A), .EW(EWA)) u_dly_d (
    .clk, .rst, .shift(push), .clear, .delay(delay_a), .din(yb_t), .dout(zb_t)
  );

  always_comb begin
    taps.c  = c_t;
    taps.xb = xb_t;
    taps.xf = xf_t;
    taps.yb = yb_t;
    taps.yf = yf_t;
    taps.zb = zb_t;
    taps.zf = newest;
  end

  a_full_primed: assert property (@(posedge clk) disable iff (rst) full |-> primed)
    else $error("volume full without first plane done");

  a_out_bounds: assert property (@(posedge clk) disable iff (rst)
    (ox <= sx_m1) && (oy <= sy_m1) && (oz <= sz_m1) &&
    (ix <= sx_m1) && (iy <= sy_m1) && (iz <= sz_m1))
    else $error("position counter beyond volume");

  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    emit && o_last |=> !full && !primed)
    else $error("volume did not restart after last voxel");

endmodule

[src/wpl3_arith.sv]
module wpl3_arith (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         enable,
  input  wpl3_pkg::taps_t              taps,
  input  wpl3_pkg::edge_ctl_t          ctl,
  input  logic                         ctl_valid,
  input  logic [wpl3_pkg::WGT_W-1:0]   wx,
  input  logic [wpl3_pkg::WGT_W-1:0]   wy,
  input  logic [wpl3_pkg::WGT_W-1:0]   wz,
  output logic                         out_valid,
  output logic signed [wpl3_pkg::LAP_W-1:0] laplacian,
  output logic                         last_voxel
);
  import wpl3_pkg::*;

  logic [PHASE_W-1:0] xf, xb, yf, yb, zf, zb;

  logic v1, v2, v3, v4, v5, v6;
  logic l1, l2, l3, l4, l5, l6;
  logic signed [PHASE_W:0] dx, dy, dz;
  logic signed [31:0] px, py, pz;
  logic signed [33:0] sum;
  logic               n4, n5, n6;
  logic [14:0]        ah;
  logic [18:0]        v;
  logic [30:0]        p1;
  logic [16:0]        p2;
  logic [10:0]        w;
  logic [30:0]        q1;
  logic [7:0]         p3;
  logic [33:0]        mag_s;
  logic [21:0]        w_prod;
  logic [30:0]        mag;

  always_comb begin
    xf = ctl.has_xf ? taps.xf : taps.c;
    xb = ctl.has_xb ? taps.xb : taps.c;
    yf = ctl.has_yf ? taps.yf : taps.c;
    yb = ctl.has_yb ? taps.yb : taps.c;
    zf = ctl.has_zf ? taps.zf : taps.c;
    zb = ctl.has_zb ? taps.zb : taps.c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (enable) begin
      v1 <= ctl_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6;
    end
  end

  assign mag_s  = sum[33] ? -sum : sum;
  assign w_prod = 22'(w) * 22'(DIV7_LO);
  assign mag    = q1 + 31'(p3);

  always_ff @(posedge clk) begin
    if (enable) begin
      // second differences
      dx <= wrap_diff(xf, xb, taps.c);
      dy <= wrap_diff(yf, yb, taps.c);
      dz <= wrap_diff(zf, zb, taps.c);
      l1 <= ctl.last;
      // weights
      px <= 32'(dx) * $signed(32'(wx));
      py <= 32'(dy) * $signed(32'(wy));
      pz <= 32'(dz) * $signed(32'(wz));
      l2 <= l1;
      sum <= 34'(px) + 34'(py) + 34'(pz);
      l3 <= l2;
      // divide |sum| by 7, then restore sign
      n4 <= sum[33];
      ah <= mag_s[32:18];
      v  <= 19'(mag_s[32:18]) + 19'(mag_s[17:0]);
      l4 <= l3;
      n5 <= n4;
      p1 <= 31'(ah) * 31'(DIV7_HI);
      p2 <= 17'(v[18:9]) * 17'(DIV7_MID);
      w  <= 11'(v[18:9]) + 11'(v[8:0]);
      l5 <= l4;
      n6 <= n5;
      q1 <= p1 + 31'(p2);
      p3 <= w_prod[DIV7_SH +: 8];
      l6 <= l5;
      laplacian  <= n6 ? -$signed(mag) : $signed(mag);
      last_voxel <= l6;
    end
  end

endmodule
